// ===== hw/rtl/bpe_pkg.sv =====
`timescale 1ns / 1ps

package bpe_pkg;

   localparam int NUM_VERTICES = 16;
   localparam int VERTEX_W     = $clog2(NUM_VERTICES);
   localparam int COUNT_W      = $clog2(NUM_VERTICES + 1);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } search_state_type;

   // query handed from the front end to the search sequencer
   typedef struct packed {
      logic                start;
      logic [VERTEX_W-1:0] source;
      logic [VERTEX_W-1:0] target;
      logic [COUNT_W-1:0]  count;
   } query_type;

   // one adjacency row update
   typedef struct packed {
      logic                    en;
      logic [VERTEX_W-1:0]     index;
      logic [NUM_VERTICES-1:0] row;
   } row_write_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [VERTEX_W-1:0] lowest_set(input logic [NUM_VERTICES-1:0] bits);
      logic [VERTEX_W-1:0] idx;
      idx = '0;
      for (int k = NUM_VERTICES - 1; k >= 0; k--) begin
         if (bits[k]) begin
            idx = VERTEX_W'(k);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hw/rtl/bpe_adj_rows.sv =====
`timescale 1ns / 1ps

module bpe_adj_rows (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bpe_pkg::row_write_type                wr,
   input  logic [bpe_pkg::VERTEX_W-1:0]          rd_index,
   output logic [bpe_pkg::NUM_VERTICES-1:0]      rd_row
);
   import bpe_pkg::*;

   logic [NUM_VERTICES-1:0] rows_ff [NUM_VERTICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_VERTICES; k++) begin
            rows_ff[k] <= '0;
         end
      end else if (wr.en) begin
         rows_ff[wr.index] <= wr.row;
      end
   end

   assign rd_row = rows_ff[rd_index];

endmodule

// ===== hw/rtl/bpe_search.sv =====
`timescale 1ns / 1ps

module bpe_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bpe_pkg::query_type                    query,
   output logic                                  idle,
   output logic [bpe_pkg::VERTEX_W-1:0]          adj_index,
   input  logic [bpe_pkg::NUM_VERTICES-1:0]      adj_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  reachable
);
   import bpe_pkg::*;

   search_state_type        state_ff, state_in;
   logic [NUM_VERTICES-1:0] seen_ff, seen_in;
   logic [NUM_VERTICES-1:0] expanded_ff, expanded_in;
   logic [VERTEX_W-1:0]     target_ff, target_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    reach_ff, reach_in;

   logic [NUM_VERTICES-1:0] pending;
   logic [NUM_VERTICES-1:0] in_use;
   logic [NUM_VERTICES-1:0] row_used;
   logic [VERTEX_W-1:0]     cur;

   always_comb begin
      for (int k = 0; k < NUM_VERTICES; k++) begin
         in_use[k] = (COUNT_W'(k) < count_ff);
      end
   end

   assign pending   = seen_ff & ~expanded_ff;
   assign cur       = lowest_set(pending);
   assign adj_index = cur;
   assign row_used  = adj_row & in_use;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      seen_ff     <= seen_in;
      expanded_ff <= expanded_in;
      target_ff   <= target_in;
      count_ff    <= count_in;
      reach_ff    <= reach_in;
   end

   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      expanded_in = expanded_ff;
      target_in   = target_ff;
      count_in    = count_ff;
      reach_in    = reach_ff;
      idle        = 1'b0;
      rsp_valid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (query.start) begin
               target_in   = query.target;
               count_in    = query.count;
               expanded_in = '0;
               reach_in    = 1'b0;
               // a source outside the vertices in use reaches nothing
               if (COUNT_W'(query.source) >= query.count) begin
                  seen_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  seen_in  = NUM_VERTICES'(1) << query.source;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (pending == '0) begin
               state_in = ST_DONE;
            end else if (row_used[target_ff]) begin
               reach_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               // expand one vertex: its neighbours join the frontier
               seen_in          = seen_ff | row_used;
               expanded_in      = expanded_ff;
               expanded_in[cur] = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign reachable = reach_ff;

endmodule

// ===== hw/rtl/bfs_path_exists.sv =====
`timescale 1ns / 1ps
// Directed-graph reachability: a row write gives no transfer out.
// A query whose source is out of use gives its result transfer in the cycle after it is taken;
// otherwise the search covers vertex_count vertices, saturated at 16: one adjacency row
// is read and merged into the visited mask per cycle by the shared expand step.
// One item is worked at a time; req_tready is low from query start until its result is taken.
// Synchronous active-high reset clears all edges and sets vertex_count to 16.

module bfs_path_exists (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // vertex [3:0], neighbor_mask [19:4], target [23:20]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // reachable [0], zero fill [7:1]
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // vertex_count
);
   import bpe_pkg::*;

   logic [4:0]              vertex_count_ff;
   logic                    req_xfer;
   opcode_type              opcode;
   logic [VERTEX_W-1:0]     vertex;
   logic [NUM_VERTICES-1:0] neighbor_mask;
   logic [VERTEX_W-1:0]     target;
   logic [COUNT_W-1:0]      count_used;
   row_write_type           row_wr;
   query_type               query;
   logic                    idle;
   logic [VERTEX_W-1:0]     adj_index;
   logic [NUM_VERTICES-1:0] adj_row;
   logic                    reachable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= 5'd16;
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   assign opcode        = opcode_type'(req_tuser);
   assign vertex        = req_tdata[3:0];
   assign neighbor_mask = req_tdata[19:4];
   assign target        = req_tdata[23:20];

   // saturate the vertex count at the matrix size
   assign count_used = (COUNT_W'(vertex_count_ff) > COUNT_W'(NUM_VERTICES))
                       ? COUNT_W'(NUM_VERTICES) : COUNT_W'(vertex_count_ff);

   assign req_tready = idle;
   assign req_xfer   = req_tvalid && req_tready;

   assign row_wr.en    = req_xfer && (opcode == OP_WRITE);
   assign row_wr.index = vertex;
   assign row_wr.row   = neighbor_mask;

   assign query.start  = req_xfer && (opcode == OP_QUERY);
   assign query.source = vertex;
   assign query.target = target;
   assign query.count  = count_used;

   bpe_adj_rows u_adj_rows (
      .clock    (clock),
      .reset    (reset),
      .wr       (row_wr),
      .rd_index (adj_index),
      .rd_row   (adj_row)
   );

   bpe_search u_search (
      .clock     (clock),
      .reset     (reset),
      .query     (query),
      .idle      (idle),
      .adj_index (adj_index),
      .adj_row   (adj_row),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .reachable (reachable)
   );

   assign rsp_tdata = {7'd0, reachable};

endmodule

// ===== sim/bfs_path_exists_tb.sv =====
`timescale 1ns / 1ps

module bfs_path_exists_tb;
   import bpe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 300;

   typedef struct {
      opcode_type              op;
      logic [VERTEX_W-1:0]     vertex;
      logic [NUM_VERTICES-1:0] mask;
      logic [VERTEX_W-1:0]     target;
   } graph_item_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_CADENCE
   } ready_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;  // vertex [3:0], neighbor_mask [19:4], target [23:20]
   logic        req_tuser   = 1'b0;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;   // reachable [0], zero fill [7:1]
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;  // vertex_count

   bfs_path_exists uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // shadow of the graph and the vertex count
   logic [NUM_VERTICES-1:0] shadow_rows [NUM_VERTICES];
   logic [4:0]              shadow_count;

   graph_item_type pending_items [$];
   bit          reach_expected [$];

   int  items_queued     = 0;
   int  items_accepted   = 0;
   int  results_checked  = 0;
   int  mismatch_count   = 0;
   int  idle_cycles      = 0;
   bit  req_taken        = 1'b0;
   int  burst_left       = 0;
   int  gap_left         = 0;
   int  hold_left        = 0;
   bit  hold_done        = 1'b0;
   int  mode_left        = 0;
   int  cadence_step     = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int  count_now        = 16;

   // closure over edges among the vertices in use; the source itself only
   // counts once some path leads back to it
   function automatic bit path_exists(input logic [VERTEX_W-1:0] src,
                                      input logic [VERTEX_W-1:0] dst);
      logic [NUM_VERTICES-1:0] in_use;
      logic [NUM_VERTICES-1:0] reach;
      logic [NUM_VERTICES-1:0] grown;
      int                      n;
      n = (int'(shadow_count) > NUM_VERTICES) ? NUM_VERTICES : int'(shadow_count);
      in_use = (n >= NUM_VERTICES) ? '1 : ((NUM_VERTICES'(1) << n) - 1'b1);
      if (int'(src) >= n) return 1'b0;
      reach = shadow_rows[src] & in_use;
      for (int round = 0; round < NUM_VERTICES; round++) begin
         grown = reach;
         for (int k = 0; k < NUM_VERTICES; k++) begin
            if (reach[k]) grown |= shadow_rows[k] & in_use;
         end
         reach = grown;
      end
      return (int'(dst) < n) && reach[dst];
   endfunction

   // posedge: update the shadow on each transfer and check results
   always @(posedge clock) begin : observe
      bit got;
      bit want;
      if (reset) begin
         for (int k = 0; k < NUM_VERTICES; k++) shadow_rows[k] = '0;
         shadow_count = 5'd16;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_wr_en) shadow_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            items_accepted++;
            if (opcode_type'(req_tuser) == OP_WRITE)
               shadow_rows[req_tdata[3:0]] = req_tdata[19:4];
            else
               reach_expected.push_back(path_exists(req_tdata[3:0], req_tdata[23:20]));
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            got = rsp_tdata[0];
            if (reach_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: tdata %h", rsp_tdata);
            end else begin
               want = reach_expected.pop_front();
               if (rsp_tdata !== {7'b0, want}) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("reachable mismatch: expected %0d, got tdata %h",
                              want, rsp_tdata);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("bfs_path_exists_tb: FAIL");
         $finish;
      end
   end

   // sender: bursts of items with random gaps between them
   always @(negedge clock) begin : drive_req
      graph_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            item = pending_items.pop_front();
            req_tdata  <= {item.target, item.mask, item.vertex};
            req_tuser  <= item.op;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: changing stall pattern, plus one long hold-off
   always @(negedge clock) begin : drive_rsp
      bit ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && results_checked >= 40) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(16, 80);
            end
            mode_left--;
            cadence_step = (cadence_step + 1) % 5;
            case (ready_mode)
               READY_ALWAYS:  ready = 1'b1;
               READY_COIN:    ready = $urandom_range(0, 1);
               READY_SPARSE:  ready = ($urandom_range(0, 3) == 0);
               default:       ready = (cadence_step < 3);
            endcase
         end
         rsp_tready <= ready;
      end
   end

   task automatic add_write(input int v, input logic [NUM_VERTICES-1:0] m);
      graph_item_type item;
      item.op     = OP_WRITE;
      item.vertex = VERTEX_W'(v);
      item.mask   = m;
      item.target = VERTEX_W'($urandom_range(0, 15));
      pending_items.push_back(item);
      items_queued++;
   endtask

   task automatic add_query(input int src, input int dst);
      graph_item_type item;
      item.op     = OP_QUERY;
      item.vertex = VERTEX_W'(src);
      item.mask   = NUM_VERTICES'($urandom());
      item.target = VERTEX_W'(dst);
      pending_items.push_back(item);
      items_queued++;
   endtask

   // mostly a vertex in use, so queries get past the first check
   function automatic int pick_vertex();
      int n;
      n = (count_now > NUM_VERTICES) ? NUM_VERTICES : count_now;
      if (n > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, n - 1);
      return $urandom_range(0, NUM_VERTICES - 1);
   endfunction

   function automatic logic [NUM_VERTICES-1:0] pick_mask();
      logic [NUM_VERTICES-1:0] m;
      case ($urandom_range(0, 5))
         0, 1: begin
            m = NUM_VERTICES'(1) << pick_vertex();
            if ($urandom_range(0, 1)) m |= NUM_VERTICES'(1) << pick_vertex();
         end
         2:       m = NUM_VERTICES'($urandom());
         3:       m = '0;
         4:       m = '1;
         default: m = NUM_VERTICES'(1) << pick_vertex();
      endcase
      return m;
   endfunction

   task automatic add_random_items(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 3) add_write(pick_vertex(), pick_mask());
         else                          add_query(pick_vertex(), pick_vertex());
      end
   endtask

   // wait until every item is taken and every result is in, then let the
   // search wind down before touching the register
   task automatic settle();
      do @(negedge clock);
      while (items_accepted != items_queued || reach_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_count(input int v);
      csr_wr_data <= 5'(v);
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      count_now = v;
   endtask

   initial begin : stimulus
      int counts [9];
      counts = '{16, 1, 2, 7, 17, 31, 0, 12, 16};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_vertex_count(16);
      add_write(0, 16'hFFFF);
      add_write(15, 16'h8000);            // self loop
      add_write(2, 16'h0008);
      add_write(3, 16'h0010);
      add_write(1, 16'h0000);
      add_write(4, 16'h0000);
      add_query(0, 0);
      add_query(15, 15);
      add_query(1, 1);                    // no edges, no cycle
      add_query(2, 4);
      add_query(4, 2);
      add_query(2, 2);
      add_query(0, 15);
      add_query(15, 0);
      add_write(14, 16'hFFFF);
      add_query(14, 3);
      settle();

      // edges into vertices out of use are dropped
      write_vertex_count(4);
      add_query(0, 3);
      add_query(0, 5);
      add_query(5, 5);
      add_query(2, 3);
      add_query(3, 4);
      settle();

      write_vertex_count(0);
      add_query(0, 0);
      settle();

      // above the vertex limit saturates
      write_vertex_count(31);
      add_query(15, 15);
      add_query(0, 15);
      settle();

      foreach (counts[i]) begin
         write_vertex_count(counts[i]);
         add_random_items(52);
         settle();
      end
      write_vertex_count($urandom_range(1, 16));
      add_random_items(20);
      settle();

      if (mismatch_count == 0 && reach_expected.size() == 0)
         $display("bfs_path_exists_tb: PASS");
      else
         $display("bfs_path_exists_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bpe_pkg.sv
hw/rtl/bpe_adj_rows.sv
hw/rtl/bpe_search.sv
hw/rtl/bfs_path_exists.sv
sim/bfs_path_exists_tb.sv
